>>> hw/rtl/id3p_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_pkg: shared types and constants of the ID3v2 text frame parser
// Transaction payloads, parse phase codes, result codes and frame ids.
// ----------------------------------------------------------------------------
package id3p_pkg;

  // longest text field that is sent, in characters
  localparam int FIELD_CHARS = 255;
  localparam int IDX_W       = $clog2(FIELD_CHARS + 1);

  // frames above this size are skipped
  localparam logic [31:0] SIZE_LIMIT = 32'd10000000;

  localparam int POS_W = 34;
  localparam int END_W = 29;

  // tag magic "ID3"
  localparam logic [7:0] MAGIC [3] = '{8'h49, 8'h44, 8'h33};

  // wanted frame ids
  localparam logic [31:0] ID_TITLE  = 32'h5449_5432;  // TIT2
  localparam logic [31:0] ID_ARTIST = 32'h5450_4531;  // TPE1
  localparam logic [31:0] ID_ALBUM  = 32'h5441_4C42;  // TALB

  // text bytes of interest
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] BOM_FF   = 8'hFF;
  localparam logic [7:0] BOM_FE   = 8'hFE;

  // text encodings
  localparam logic [7:0] ENC_LATIN1  = 8'd0;
  localparam logic [7:0] ENC_UTF16   = 8'd1;
  localparam logic [7:0] ENC_UTF16BE = 8'd2;
  localparam logic [7:0] ENC_UTF8    = 8'd3;

  // result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // field codes
  localparam logic [1:0] FIELD_TITLE  = 2'd0;
  localparam logic [1:0] FIELD_ARTIST = 2'd1;
  localparam logic [1:0] FIELD_ALBUM  = 2'd2;

  localparam logic [2:0] ALL_FOUND = 3'b111;

  // result queue
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [5:0] {
    PH_TAGHDR = 6'b000001,
    PH_FRMHDR = 6'b000010,
    PH_SKIP   = 6'b000100,
    PH_ENC    = 6'b001000,
    PH_TEXT   = 6'b010000,
    PH_IDLE   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [1:0] field_select;
    logic [7:0] char_index;
    logic [7:0] char_value;
    logic [7:0] field_length;
    logic [2:0] found_mask;
    logic       tag_ok;
    logic       last_result;
  } result_t;

  // results of one parse step toward the result queue
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    phase_e           phase;
    logic [POS_W-1:0] pos;
    logic [2:0]       version;
    logic [END_W-1:0] tag_end;
    logic [31:0]      bytes_left;
    logic [1:0]       target;
    logic             utf16;
    logic             big_endian;
    logic [7:0]       held;
    logic [IDX_W-1:0] out_idx;
    logic [IDX_W-1:0] kept;
    logic             ended;
    logic [2:0]       found;
    logic [3:0]       hdr_cnt;
    logic             pair_half;
    logic             first_pair;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:      PH_TAGHDR,
    pos:        '0,
    version:    '0,
    tag_end:    '0,
    bytes_left: '0,
    target:     '0,
    utf16:      1'b0,
    big_endian: 1'b0,
    held:       '0,
    out_idx:    '0,
    kept:       '0,
    ended:      1'b0,
    found:      '0,
    hdr_cnt:    '0,
    pair_half:  1'b0,
    first_pair: 1'b0
  };

endpackage
`default_nettype wire

>>> hw/rtl/id3p_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_step: parse step of the ID3v2 text frame parser
// Holds the parse state and turns one byte into up to two results.
// ----------------------------------------------------------------------------
module id3p_step
  import id3p_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  output push_t         push_o
);

  parse_state_t st_q, st_d, cur;
  logic [7:0]   hdr_q [8];

  logic [7:0]   b;
  logic [POS_W:0] next_pos;
  logic         finish, finish_all, closed, want_next, have_char;
  logic [IDX_W-1:0] cidx;
  logic [7:0]   cval;
  logic [7:0]   tch;
  logic         take;
  logic         hdr_we;
  logic [2:0]   hdr_addr;
  logic [31:0]  hdr_len;
  logic [31:0]  left_dec;
  logic [31:0]  hdr_ident;
  logic         bom;
  logic [7:0]   lo, hi;
  result_t      char_r, end_r;
  logic         has_end;

  assign b   = item_i.in_byte;
  // start of file restarts the parser before the byte is taken
  assign cur = item_i.start_of_file ? STATE_RESET : st_q;

  assign next_pos  = {1'b0, cur.pos} + {{POS_W{1'b0}}, 1'b1};
  assign left_dec  = cur.bytes_left - 32'd1;
  assign hdr_ident = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};

  // frame size, syncsafe in version 4
  always_comb begin
    if (cur.version == 3'd4) begin
      hdr_len = {4'b0, hdr_q[4][6:0], hdr_q[5][6:0], hdr_q[6][6:0], hdr_q[7][6:0]};
    end else begin
      hdr_len = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
    end
  end

  // next state for one byte
  always_comb begin
    st_d      = cur;
    st_d.pos  = next_pos[POS_W-1:0];
    finish    = 1'b0;
    closed    = 1'b0;
    want_next = 1'b0;
    take      = 1'b0;
    tch       = b;
    hdr_we    = 1'b0;
    hdr_addr  = cur.hdr_cnt[2:0];
    bom       = 1'b0;
    lo        = cur.big_endian ? b : cur.held;
    hi        = cur.big_endian ? cur.held : b;

    case (cur.phase)
      PH_TAGHDR: begin
        if (cur.pos < POS_W'(3)) begin
          if (b != MAGIC[cur.pos[1:0]]) begin
            finish = 1'b1;
          end
        end else if (cur.pos == POS_W'(3)) begin
          if (b < 8'd2 || b > 8'd4) begin
            finish = 1'b1;
          end else begin
            st_d.version = b[2:0];
          end
        end else if (cur.pos >= POS_W'(6)) begin
          st_d.tag_end = {1'b0, cur.tag_end[20:0], b[6:0]};
          if (cur.pos >= POS_W'(9)) begin
            st_d.tag_end = {1'b0, cur.tag_end[20:0], b[6:0]} + END_W'(10);
            want_next    = 1'b1;
          end
        end
      end
      PH_FRMHDR: begin
        if (cur.hdr_cnt == 4'd0 && b == 8'd0) begin
          finish = 1'b1;
        end else begin
          hdr_we       = (cur.hdr_cnt < 4'd8);
          st_d.hdr_cnt = cur.hdr_cnt + 4'd1;
          if (cur.hdr_cnt >= 4'd9) begin
            st_d.bytes_left = hdr_len;
            if (hdr_len == 32'd0) begin
              want_next = 1'b1;
            end else begin
              st_d.phase = PH_SKIP;
              if (hdr_len > 32'd1 && hdr_len <= SIZE_LIMIT) begin
                if (hdr_ident == ID_TITLE) begin
                  st_d.target = FIELD_TITLE;
                  st_d.phase  = PH_ENC;
                end else if (hdr_ident == ID_ARTIST) begin
                  st_d.target = FIELD_ARTIST;
                  st_d.phase  = PH_ENC;
                end else if (hdr_ident == ID_ALBUM) begin
                  st_d.target = FIELD_ALBUM;
                  st_d.phase  = PH_ENC;
                end
              end
            end
          end
        end
      end
      PH_SKIP: begin
        st_d.bytes_left = left_dec;
        if (left_dec == 32'd0) begin
          want_next = 1'b1;
        end
      end
      PH_ENC: begin
        st_d.bytes_left = left_dec;
        st_d.out_idx    = '0;
        st_d.kept       = '0;
        st_d.ended      = 1'b0;
        st_d.pair_half  = 1'b0;
        st_d.first_pair = 1'b1;
        st_d.held       = '0;
        st_d.big_endian = (b == ENC_UTF16BE);
        st_d.utf16      = (b == ENC_UTF16 || b == ENC_UTF16BE);
        st_d.phase      = (b <= ENC_UTF8) ? PH_TEXT : PH_SKIP;
      end
      PH_TEXT: begin
        if (!cur.utf16) begin
          // latin-1 and utf-8 are copied up to the first nul
          if (!cur.ended) begin
            if (b == 8'd0) begin
              st_d.ended = 1'b1;
            end else begin
              take = 1'b1;
            end
          end
        end else if (!cur.pair_half) begin
          st_d.held      = b;
          st_d.pair_half = 1'b1;
        end else begin
          st_d.pair_half = 1'b0;
          // byte order mark on the opening pair
          if (cur.first_pair) begin
            st_d.first_pair = 1'b0;
            if ((cur.held == BOM_FF && b == BOM_FE) ||
                (cur.held == BOM_FE && b == BOM_FF)) begin
              bom             = 1'b1;
              st_d.big_endian = (cur.held == BOM_FE);
            end
          end
          if (!bom && !cur.ended) begin
            if (hi == 8'd0 && lo >= CH_SPACE && lo < CH_DEL) begin
              take = 1'b1;
              tch  = lo;
            end else if (hi == 8'd0 && lo == 8'd0) begin
              st_d.ended = 1'b1;
            end
          end
        end
        st_d.bytes_left = left_dec;
        if (left_dec == 32'd0) begin
          closed = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // character into the field, up to the field limit
    have_char = take && (cur.out_idx < IDX_W'(FIELD_CHARS));
    cidx      = cur.out_idx;
    cval      = tch;
    if (have_char) begin
      st_d.out_idx = cur.out_idx + IDX_W'(1);
      if (tch != CH_SPACE) begin
        st_d.kept = cur.out_idx + IDX_W'(1);
      end
    end

    // field close sets its found bit when its trimmed length is non-zero
    if (closed) begin
      want_next = 1'b1;
      if (st_d.kept != '0) begin
        st_d.found = cur.found | (3'b001 << cur.target);
      end
    end

    // frame boundary: next header or end of walk
    if (want_next) begin
      if (next_pos < {{(POS_W + 1 - END_W){1'b0}}, st_d.tag_end} &&
          st_d.found != ALL_FOUND) begin
        st_d.phase   = PH_FRMHDR;
        st_d.hdr_cnt = 4'd0;
      end else begin
        finish = 1'b1;
      end
    end

    finish_all = finish || (item_i.end_of_file && cur.phase != PH_IDLE);
    if (finish_all) begin
      st_d.phase = PH_IDLE;
    end
  end

  // result words
  always_comb begin
    char_r              = '0;
    char_r.result_kind  = KIND_CHAR;
    char_r.field_select = cur.target;
    char_r.char_index   = 8'(cidx);
    char_r.char_value   = cval;

    end_r = '0;
    if (finish_all) begin
      end_r.result_kind  = KIND_DONE;
      end_r.field_select = closed ? cur.target : FIELD_TITLE;
      end_r.char_value   = closed ? 8'd1 : 8'd0;
      end_r.field_length = closed ? 8'(st_d.kept) : 8'd0;
      end_r.found_mask   = st_d.found;
      end_r.tag_ok       = (st_d.found != 3'b000);
    end else begin
      end_r.result_kind  = KIND_FIELD;
      end_r.field_select = cur.target;
      end_r.field_length = 8'(st_d.kept);
    end
    end_r.last_result = 1'b1;
    has_end           = finish_all || closed;

    char_r.last_result = !has_end;
    push_o.first  = have_char ? char_r : end_r;
    push_o.second = end_r;
    push_o.count  = fire_i ? ({1'b0, have_char} + {1'b0, has_end}) : 2'd0;
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  // frame header bytes
  always_ff @(posedge clk_i) begin
    if (fire_i && hdr_we) begin
      hdr_q[hdr_addr] <= b;
    end
  end

  // a finished parse leaves the walk idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && finish_all |=> st_q.phase == PH_IDLE)
    else $error("parse did not go idle after finishing");

  // two results are always a character then a field close or final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |-> push_o.first.result_kind == KIND_CHAR &&
      !push_o.first.last_result && push_o.second.result_kind != KIND_CHAR)
    else $error("bad result pair");

  // idle parse is silent until a new file starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !item_i.start_of_file && st_q.phase == PH_IDLE |-> push_o.count == 2'd0)
    else $error("result while idle");

endmodule
`default_nettype wire

>>> hw/rtl/id3p_res_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3p_res_fifo: result queue of the ID3v2 text frame parser
// Takes up to two results a cycle and hands out one per transaction.
// ----------------------------------------------------------------------------
module id3p_res_fifo
  import id3p_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output result_t    out_o
);

  result_t              mem_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]  wr_q, rd_q;
  logic [RQ_CNT_W-1:0]  cnt_q;
  logic                 pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a full step of two results
  assign room_o      = (cnt_q <= RQ_CNT_W'(RQ_DEPTH - 2));

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + RQ_PTR_W'(push_i.count);
      rd_q  <= rd_q + RQ_PTR_W'(pop);
      cnt_q <= cnt_q + RQ_CNT_W'(push_i.count) - RQ_CNT_W'(pop);
    end
  end

  // entry writes
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + RQ_PTR_W'(1)] <= push_i.second;
    end
  end

  // never overfilled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue overflow");

  // pushes only land with room for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o && push_i.count != 2'd3)
    else $error("push without room");

  // a waiting result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("waiting result dropped or changed");

endmodule
`default_nettype wire

>>> hw/rtl/id3v2_text_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// id3v2_text_frame_parser: ID3v2 title, artist and album extractor
// Input register, single-pass parse step and a four-entry result queue.
// ----------------------------------------------------------------------------
// The block takes one file byte per transaction and returns the characters of
// the TIT2, TPE1 and TALB text frames, a close result per field with its
// trimmed length, and a final result with the found mask. A taken byte is held
// in the input register and parsed from there, and its results are written into
// the result queue, from which they leave. The sustained rate is one byte per
// cycle while each byte causes at most one result and the output side is ready;
// a byte that emits a character and closes a field has two results, and the
// single output port of the result queue then sets the pace at one result per
// cycle. A byte is parsed only when the result queue has room for two results.
module id3v2_text_frame_parser
  import id3p_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output result_t       out_o
);

  in_item_t in_q;
  logic     in_valid_q;
  logic     room;
  logic     fire;
  push_t    push;

  assign fire       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  // parse step
  id3p_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_q),
    .push_o (push)
  );

  // result queue
  id3p_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire

>>> tb/tb_id3v2_text_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_id3v2_text_frame_parser: self-checking bench of the ID3v2 text parser
// Feeds files byte by byte, with short hand-built files first and then
// random tags of mixed versions, frames and text encodings. A behavioral
// parser in the bench predicts every result, and the results returned by the
// block are checked in order, field by field. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_id3v2_text_frame_parser
  import id3p_pkg::*;
();

  localparam int  FEED_BYTES   = 1850;
  localparam int  LIMIT_CYCLES = 1000000;
  localparam int  DRAIN_CYCLES = 20;
  localparam int  HOLD_CYCLES  = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     byte_valid = 1'b0;
  logic     byte_ready;
  in_item_t byte_item = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  result_t  res_item;

  // bytes waiting to be sent, results waiting to be returned
  in_item_t   byte_feed_q[$];
  result_t    tag_results_q[$];
  logic [7:0] file_buf[$];
  logic [7:0] frame_body[$];

  int mismatch_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int tx_gap = 0, tx_calm = 0;
  int rx_stall = 0, rx_calm = 0, hold_left = 0;

  // predicted parser state
  phase_e      ps_phase;
  logic [33:0] ps_pos;
  logic [2:0]  ps_ver;
  logic [31:0] ps_tag_end;
  logic [7:0]  ps_hdr [8];
  int          ps_hdr_cnt;
  logic [31:0] ps_left;
  logic [1:0]  ps_target;
  logic [7:0]  ps_enc;
  logic        ps_big_endian;
  logic [7:0]  ps_held;
  int          ps_out_idx;
  int          ps_kept;
  logic        ps_ended;
  logic        ps_pair_half;
  logic        ps_first_pair;
  logic [2:0]  ps_found;

  // character taken by the current byte
  logic       step_char;
  logic [7:0] step_idx;
  logic [7:0] step_val;

  id3v2_text_frame_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_valid),
    .in_ready_o  (byte_ready),
    .in_i        (byte_item),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_o       (res_item)
  );

  always #2 clk_i = ~clk_i;

  function automatic void restart_parse();
    ps_phase      = PH_TAGHDR;
    ps_pos        = '0;
    ps_ver        = '0;
    ps_tag_end    = '0;
    for (int i = 0; i < 8; i++) ps_hdr[i] = '0;
    ps_hdr_cnt    = 0;
    ps_left       = '0;
    ps_target     = FIELD_TITLE;
    ps_enc        = ENC_LATIN1;
    ps_big_endian = 1'b0;
    ps_held       = '0;
    ps_out_idx    = 0;
    ps_kept       = 0;
    ps_ended      = 1'b0;
    ps_pair_half  = 1'b0;
    ps_first_pair = 1'b0;
    ps_found      = '0;
  endfunction

  // at a frame boundary: go on with the next header, or report the end
  function automatic logic walk_ends(longint unsigned next_pos);
    if (next_pos < longint'(ps_tag_end) && ps_found != ALL_FOUND) begin
      ps_phase   = PH_FRMHDR;
      ps_hdr_cnt = 0;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_char(logic [7:0] c);
    if (ps_out_idx < FIELD_CHARS) begin
      step_char = 1'b1;
      step_idx  = ps_out_idx[7:0];
      step_val  = c;
      ps_out_idx++;
      if (c != CH_SPACE) ps_kept = ps_out_idx;
    end
  endfunction

  // one file byte through the parser, expected results queued in order
  task automatic parse_byte(input in_item_t it);
    logic [7:0]      b;
    logic            finish;
    logic            closed;
    logic            bom;
    logic [7:0]      lo;
    logic [7:0]      hi;
    logic [31:0]     size;
    logic [31:0]     hdr_ident;
    longint unsigned cur;
    longint unsigned nxt;
    result_t         r;
    b         = it.in_byte;
    finish    = 1'b0;
    closed    = 1'b0;
    step_char = 1'b0;
    if (it.start_of_file) restart_parse();
    cur    = ps_pos;
    nxt    = cur + 1;
    ps_pos = nxt[33:0];
    case (ps_phase)
      PH_TAGHDR: begin
        if (cur < 3) begin
          if (b != MAGIC[cur[1:0]]) finish = 1'b1;
        end else if (cur == 3) begin
          if (b < 2 || b > 4) finish = 1'b1;
          else ps_ver = b[2:0];
        end else if (cur >= 6) begin
          ps_tag_end = ((ps_tag_end << 7) | {25'd0, b[6:0]}) & 32'h0FFF_FFFF;
          if (cur >= 9) begin
            ps_tag_end = ps_tag_end + 32'd10;
            finish = walk_ends(nxt);
          end
        end
      end
      PH_FRMHDR: begin
        if (ps_hdr_cnt == 0 && b == 8'h00) begin
          finish = 1'b1;
        end else begin
          if (ps_hdr_cnt < 8) ps_hdr[ps_hdr_cnt] = b;
          ps_hdr_cnt++;
          if (ps_hdr_cnt >= 10) begin
            if (ps_ver == 3'd4)
              size = {4'd0, ps_hdr[4][6:0], ps_hdr[5][6:0], ps_hdr[6][6:0], ps_hdr[7][6:0]};
            else
              size = {ps_hdr[4], ps_hdr[5], ps_hdr[6], ps_hdr[7]};
            ps_left = size;
            if (size == 0) begin
              finish = walk_ends(nxt);
            end else begin
              ps_phase  = PH_SKIP;
              hdr_ident = {ps_hdr[0], ps_hdr[1], ps_hdr[2], ps_hdr[3]};
              if (size > 1 && size <= SIZE_LIMIT) begin
                case (hdr_ident)
                  ID_TITLE: begin
                    ps_target = FIELD_TITLE;
                    ps_phase  = PH_ENC;
                  end
                  ID_ARTIST: begin
                    ps_target = FIELD_ARTIST;
                    ps_phase  = PH_ENC;
                  end
                  ID_ALBUM: begin
                    ps_target = FIELD_ALBUM;
                    ps_phase  = PH_ENC;
                  end
                  default: ;
                endcase
              end
            end
          end
        end
      end
      PH_SKIP: begin
        ps_left = ps_left - 1;
        if (ps_left == 0) finish = walk_ends(nxt);
      end
      PH_ENC: begin
        ps_enc        = b;
        ps_left       = ps_left - 1;
        ps_out_idx    = 0;
        ps_kept       = 0;
        ps_ended      = 1'b0;
        ps_pair_half  = 1'b0;
        ps_first_pair = 1'b1;
        ps_held       = '0;
        ps_big_endian = (b == ENC_UTF16BE);
        ps_phase      = (b <= ENC_UTF8) ? PH_TEXT : PH_SKIP;
      end
      PH_TEXT: begin
        if (ps_enc == ENC_LATIN1 || ps_enc == ENC_UTF8) begin
          // byte encodings: copy up to the first nul
          if (!ps_ended) begin
            if (b == 8'h00) ps_ended = 1'b1;
            else take_char(b);
          end
        end else if (!ps_pair_half) begin
          ps_held      = b;
          ps_pair_half = 1'b1;
        end else begin
          // utf-16 pair: bom on the first pair, printable ascii kept
          bom          = 1'b0;
          ps_pair_half = 1'b0;
          if (ps_first_pair) begin
            ps_first_pair = 1'b0;
            if ((ps_held == BOM_FF && b == BOM_FE) || (ps_held == BOM_FE && b == BOM_FF)) begin
              bom           = 1'b1;
              ps_big_endian = (ps_held == BOM_FE);
            end
          end
          if (!bom && !ps_ended) begin
            lo = ps_big_endian ? b : ps_held;
            hi = ps_big_endian ? ps_held : b;
            if (hi == 8'h00 && lo >= CH_SPACE && lo < CH_DEL) take_char(lo);
            else if (hi == 8'h00 && lo == 8'h00) ps_ended = 1'b1;
          end
        end
        ps_left = ps_left - 1;
        if (ps_left == 0) begin
          closed = 1'b1;
          if (ps_kept != 0) ps_found[ps_target] = 1'b1;
          finish = walk_ends(nxt);
        end
      end
      default: ;
    endcase

    if (it.end_of_file && ps_phase != PH_IDLE) finish = 1'b1;
    if (finish) ps_phase = PH_IDLE;

    if (step_char) begin
      r              = '0;
      r.result_kind  = KIND_CHAR;
      r.field_select = ps_target;
      r.char_index   = step_idx;
      r.char_value   = step_val;
      r.last_result  = !(finish || closed);
      tag_results_q.push_back(r);
    end
    if (finish || closed) begin
      r              = '0;
      r.result_kind  = finish ? KIND_DONE : KIND_FIELD;
      r.last_result  = 1'b1;
      if (closed) begin
        r.field_select = ps_target;
        r.field_length = ps_kept[7:0];
        r.char_value   = finish ? 8'd1 : 8'd0;
      end
      if (finish) begin
        r.found_mask = ps_found;
        r.tag_ok     = (ps_found != 3'b000);
      end
      tag_results_q.push_back(r);
    end
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // text byte: mostly printable, some spaces, a few nuls and high bytes
  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(8'h21, 8'h7E));
    if (r < 85) return CH_SPACE;
    if (r < 88) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  // syncsafe size bytes, top bits set now and then since they are ignored
  function automatic logic [31:0] syncsafe(logic [27:0] v);
    logic [31:0] w;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = {($urandom_range(0, 7) == 0), v[7*i +: 7]};
    return w;
  endfunction

  task automatic send_file(input int keep, input logic with_eof);
    in_item_t it;
    for (int i = 0; i < keep; i++) begin
      it.in_byte       = file_buf[i];
      it.start_of_file = (i == 0);
      it.end_of_file   = with_eof && (i == keep - 1);
      byte_feed_q.push_back(it);
    end
  endtask

  // one random file: tag header, frames, padding and trailing audio bytes
  task automatic gen_file(output int useful);
    int          ver, nfr, n, r, enc, tag_len, body_len, keep;
    logic [31:0] id, size, ss;
    logic        be, with_eof;
    logic [7:0]  lo, hi;
    file_buf.delete();
    r   = $urandom_range(0, 99);
    ver = (r < 45) ? 3 : (r < 85) ? 4 : 2;
    if ($urandom_range(0, 39) == 0)
      ver = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(5, 255);
    file_buf = '{8'h49, 8'h44, 8'h33, ver[7:0], 8'h00, 8'($urandom_range(0, 255)),
                 8'h00, 8'h00, 8'h00, 8'h00};
    if ($urandom_range(0, 39) == 0)
      file_buf[$urandom_range(0, 2)] ^= (8'h01 << $urandom_range(0, 7));

    nfr = $urandom_range(0, 5);
    for (int f = 0; f < nfr; f++) begin
      r = $urandom_range(0, 99);
      if (r < 25) id = ID_TITLE;
      else if (r < 50) id = ID_ARTIST;
      else if (r < 72) id = ID_ALBUM;
      else if (r < 86) id = 32'h5443_4F4E;
      else id = $urandom();

      // frame body: encoding byte, then text in that encoding
      r   = $urandom_range(0, 99);
      enc = (r < 35) ? 0 : (r < 55) ? 1 : (r < 70) ? 2 : (r < 95) ? 3 : $urandom_range(4, 255);
      n   = ($urandom_range(0, 39) == 0) ? $urandom_range(200, 300) : $urandom_range(0, 12);
      frame_body.delete();
      frame_body.push_back(enc[7:0]);
      if (enc == 1 || enc == 2) begin
        be = (enc == 2);
        if ($urandom_range(0, 1)) begin
          be = $urandom_range(0, 1);
          frame_body.push_back(be ? BOM_FE : BOM_FF);
          frame_body.push_back(be ? BOM_FF : BOM_FE);
        end
        for (int i = 0; i < n; i++) begin
          lo = text_char();
          hi = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
          frame_body.push_back(be ? hi : lo);
          frame_body.push_back(be ? lo : hi);
        end
        if ($urandom_range(0, 4) == 0) frame_body.push_back(text_char());
      end else begin
        for (int i = 0; i < n; i++) frame_body.push_back(text_char());
      end

      // odd frame sizes: empty, encoding byte only, at the limit, oversized
      size = frame_body.size();
      r    = $urandom_range(0, 99);
      if (r < 4) begin
        size = 0;
        frame_body.delete();
      end else if (r < 8) begin
        size = 1;
        frame_body.delete();
        frame_body.push_back(enc[7:0]);
      end else if (r < 9) begin
        size = SIZE_LIMIT - 1 + $urandom_range(0, 2);
      end else if (r < 11) begin
        size = (ver == 4) ? $urandom_range(SIZE_LIMIT + 1, 32'h0FFF_FFFF)
                          : $urandom_range(SIZE_LIMIT + 1, 32'hFFFF_FFFF);
      end

      for (int i = 3; i >= 0; i--) file_buf.push_back(id[8*i +: 8]);
      ss = (ver == 4) ? syncsafe(size[27:0]) : size;
      for (int i = 3; i >= 0; i--) file_buf.push_back(ss[8*i +: 8]);
      file_buf.push_back(8'($urandom_range(0, 255)));
      file_buf.push_back(8'($urandom_range(0, 255)));
      foreach (frame_body[i]) file_buf.push_back(frame_body[i]);
    end

    // padding, mostly zeros
    n = $urandom_range(0, 6);
    r = $urandom_range(0, 99);
    for (int i = 0; i < n; i++)
      file_buf.push_back((r < 80) ? 8'h00 : 8'($urandom_range(0, 255)));

    // tag size: exact, cut short, or past the content
    tag_len = file_buf.size();
    r = $urandom_range(0, 99);
    if (r < 70) body_len = tag_len - 10;
    else if (r < 85) body_len = $urandom_range(0, tag_len - 10);
    else body_len = tag_len - 10 + $urandom_range(1, 20);
    ss = syncsafe(body_len[27:0]);
    for (int i = 0; i < 4; i++) file_buf[6 + i] = ss[8*(3-i) +: 8];

    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom_range(0, 255)));

    // file end: normal, truncated, or abandoned by the next file
    r        = $urandom_range(0, 99);
    keep     = file_buf.size();
    with_eof = 1'b1;
    if (r < 10) keep = $urandom_range(1, file_buf.size());
    else if (r < 15) with_eof = 1'b0;
    send_file(keep, with_eof);
    useful = (keep < tag_len) ? keep : tag_len;
  endtask

  // stimulus, reset and end of run
  initial begin
    int fed;
    int useful;
    restart_parse();

    // bad magic, then a byte that must be ignored
    file_buf = '{8'hFF, 8'h49};
    send_file(2, 1'b0);
    // good magic, unsupported major version
    file_buf = '{8'h49, 8'h44, 8'h33, 8'h05};
    send_file(4, 1'b1);
    // v4, all-ones tag size, title of one high byte whose last byte also ends the file
    file_buf = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                 8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
                 8'h00, 8'hFF};
    send_file(22, 1'b1);

    fed = 0;
    while (fed < FEED_BYTES) begin
      gen_file(useful);
      fed += useful;
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed_q.size() != 0 || byte_valid) @(posedge clk_i);
    while (tag_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[id3v2_text_frame_parser] OK");
    end else begin
      $display("[id3v2_text_frame_parser] ERROR");
    end
    $finish;
  end

  // byte sender: predicts on every transaction, then offers the next byte
  always @(posedge clk_i) begin : drive_bytes
    in_item_t next_item;
    logic     next_valid;
    if (rst_ni) begin
      if (byte_valid && byte_ready) parse_byte(byte_item);
      if (!byte_valid || byte_ready) begin
        next_item  = byte_item;
        next_valid = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (byte_feed_q.size() != 0) begin
          next_item  = byte_feed_q.pop_front();
          next_valid = 1'b1;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = pick_gap();
            if ($urandom_range(0, 99) == 0) tx_calm = $urandom_range(30, 150);
          end
        end
        byte_valid <= next_valid;
        byte_item  <= next_item;
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result receiver: compares each transaction, stalls at random
  always @(posedge clk_i) begin : collect_results
    result_t want;
    if (rst_ni) begin
      if (res_valid && res_ready) begin
        if (tag_results_q.size() == 0) begin
          $error("result kind %0d with nothing expected", res_item.result_kind);
          mismatch_count++;
        end else begin
          want = tag_results_q.pop_front();
          check_field("result_kind", want.result_kind, res_item.result_kind);
          check_field("field_select", want.field_select, res_item.field_select);
          check_field("char_index", want.char_index, res_item.char_index);
          check_field("char_value", want.char_value, res_item.char_value);
          check_field("field_length", want.field_length, res_item.field_length);
          check_field("found_mask", want.found_mask, res_item.found_mask);
          check_field("tag_ok", want.tag_ok, res_item.tag_ok);
          check_field("last_result", want.last_result, res_item.last_result);
        end
        results_seen++;
        // long hold-off so the result queue fills and the input stalls
        if (results_seen == 100 || results_seen == 700) begin
          hold_left = HOLD_CYCLES;
        end else if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = pick_gap();
          if ($urandom_range(0, 99) == 0) rx_calm = $urandom_range(30, 150);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $error("timeout, %0d results outstanding", tag_results_q.size());
      $display("[id3v2_text_frame_parser] ERROR");
      $finish;
    end
  end

endmodule
